[src/bba_pkg.sv]
`timescale 1ns / 1ps
package bba_pkg;

    localparam int PAGE_BYTES      = 4096;
    localparam int HEADER_BYTES    = 32;
    localparam int NUM_PAGES       = 16;
    localparam int MIN_BLOCK_BYTES = 64;
    localparam int SMALLEST_REQ    = 8;

    localparam int SLOTS_PER_PAGE = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int SLOT_BITS      = $clog2(SLOTS_PER_PAGE);
    localparam int PAGE_BITS      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int IDX_BITS       = PAGE_BITS + SLOT_BITS;
    localparam int TOP_ORDER      = SLOT_BITS;
    localparam int ORD_BITS       = 3;
    localparam int MIN_BITS       = $clog2(MIN_BLOCK_BYTES);

    typedef enum logic [1:0] {
        ST_GRANT   = 2'd0,
        ST_ZERO    = 2'd1,
        ST_LARGE   = 2'd2,
        ST_EXHAUST = 2'd3
    } status_t;

    typedef struct packed {
        status_t              kind;
        logic [ORD_BITS-1:0]  need;
    } item_t;

endpackage

[src/buddy_block_allocator.sv]
`timescale 1ns / 1ps
// A refused request (zero or too large) is answered from idle without a walk; a grant
// walks the open pages first fit, reading and checking each block, opens a new page
// if none fits, then halves down to the need. Exhaustion: no fit with all pages open.
// Throughput: one request at a time in the walk unit; a 2-entry queue takes new
// requests meanwhile. The walk hops from block start to block start in the slot RAM.
// Reset (rst_n low, asynchronous) empties the queue and closes all pages.
module buddy_block_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // request_bytes[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], data_offset[17:2], block_order[20:18]
);
    import bba_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    bba_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bba_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[src/bba_front.sv]
`timescale 1ns / 1ps
module bba_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [15:0]    s_tdata,
    output logic           q_valid,
    output bba_pkg::item_t q_item,
    input  logic           q_pop
);
    import bba_pkg::*;

    item_t      entry_reg [2];
    logic [1:0] count_reg;
    item_t      cls;
    logic [16:0] total;
    logic       push;

    always_comb
    begin
        cls.kind = ST_GRANT;
        cls.need = ORD_BITS'(TOP_ORDER);
        if (s_tdata < 16'(SMALLEST_REQ))
            total = 17'(SMALLEST_REQ + HEADER_BYTES);
        else
            total = {1'b0, s_tdata} + 17'(HEADER_BYTES);
        // Smallest order whose block holds the total; scan from the top down.
        for (int n = TOP_ORDER; n >= 0; n--)
        begin
            if (total <= 17'(MIN_BLOCK_BYTES << n))
                cls.need = ORD_BITS'(n);
        end
        if (s_tdata == 16'd0)
            cls.kind = ST_ZERO;
        else if (total > 17'(PAGE_BYTES))
            cls.kind = ST_LARGE;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            if (push && q_pop)
            begin
                if (count_reg == 2'd1)
                    entry_reg[0] <= cls;
                else
                begin
                    entry_reg[0] <= entry_reg[1];
                    entry_reg[1] <= cls;
                end
            end
            else if (q_pop)
            begin
                entry_reg[0] <= entry_reg[1];
                count_reg    <= count_reg - 2'd1;
            end
            else if (push)
            begin
                if (count_reg == 2'd0)
                    entry_reg[0] <= cls;
                else
                    entry_reg[1] <= cls;
                count_reg <= count_reg + 2'd1;
            end
        end
    end

endmodule

[src/bba_engine.sv]
`timescale 1ns / 1ps
module bba_engine
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  bba_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata  // status[1:0], data_offset[17:2], block_order[20:18]
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_OPEN,
        S_SPLIT
    } state_t;

    localparam int ENTRY_BITS = ORD_BITS + 1;

    state_t                state_reg;
    logic [ENTRY_BITS-1:0] mem [NUM_PAGES * SLOTS_PER_PAGE];
    logic [ENTRY_BITS-1:0] rd_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [ORD_BITS-1:0]   need_reg;
    logic [ORD_BITS-1:0]   ord_reg;
    logic [PAGE_BITS:0]    pages_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [15:0]           out_offset_reg;
    logic [ORD_BITS-1:0]   out_order_reg;

    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic                  rd_used;
    logic [ORD_BITS-1:0]   rd_ord;
    logic [SLOT_BITS:0]    next_slot;
    logic [PAGE_BITS:0]    next_page;
    logic [ORD_BITS-1:0]   half_ord;

    assign rd_used   = rd_reg[ENTRY_BITS-1];
    assign rd_ord    = rd_reg[ORD_BITS-1:0];
    assign next_slot = {1'b0, idx_reg[SLOT_BITS-1:0]} + ((SLOT_BITS+1)'(1) << rd_ord);
    assign next_page = {1'b0, idx_reg[IDX_BITS-1:SLOT_BITS]} + (PAGE_BITS+1)'(1);
    assign half_ord  = ord_reg - ORD_BITS'(1);

    assign q_pop    = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_order_reg, out_offset_reg, out_status_reg};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {1'b1, ord_reg};
        if (state_reg == S_SPLIT)
        begin
            wr_en = 1'b1;
            if (ord_reg > need_reg)
            begin
                // The right half of the split stays free.
                wr_addr = idx_reg + (IDX_BITS'(1) << half_ord);
                wr_data = {1'b0, half_ord};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        need_reg <= q_item.need;
                        idx_reg  <= '0;
                        if (q_item.kind != ST_GRANT)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= q_item.kind;
                            out_offset_reg <= 16'd0;
                            out_order_reg  <= '0;
                        end
                        else if (pages_reg == '0)
                            state_reg <= S_OPEN;
                        else
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (!rd_used && rd_ord >= need_reg)
                    begin
                        ord_reg   <= rd_ord;
                        state_reg <= S_SPLIT;
                    end
                    else if (next_slot[SLOT_BITS])
                    begin
                        if (next_page == pages_reg)
                            state_reg <= S_OPEN;
                        else
                        begin
                            idx_reg   <= {next_page[PAGE_BITS-1:0], SLOT_BITS'(0)};
                            state_reg <= S_READ;
                        end
                    end
                    else
                    begin
                        idx_reg   <= {idx_reg[IDX_BITS-1:SLOT_BITS], next_slot[SLOT_BITS-1:0]};
                        state_reg <= S_READ;
                    end
                end
                S_OPEN:
                begin
                    if (pages_reg == (PAGE_BITS+1)'(NUM_PAGES))
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_EXHAUST;
                        out_offset_reg <= 16'd0;
                        out_order_reg  <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= {pages_reg[PAGE_BITS-1:0], SLOT_BITS'(0)};
                        ord_reg   <= ORD_BITS'(TOP_ORDER);
                        pages_reg <= pages_reg + (PAGE_BITS+1)'(1);
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    if (ord_reg > need_reg)
                        ord_reg <= half_ord;
                    else
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_GRANT;
                        out_offset_reg <= 16'({idx_reg, MIN_BITS'(0)} + HEADER_BYTES);
                        out_order_reg  <= ord_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[tb/buddy_block_allocator_tb.sv]
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
    import bba_pkg::*;

    typedef struct {
        status_t     kind;
        logic [15:0] offset;
        logic [2:0]  order;
    } grant_t;

    int fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Tracks the block pool and holds predicted results in arrival order.
    class pool_scoreboard;
        localparam int TOTAL = NUM_PAGES * SLOTS_PER_PAGE;
        bit       used[TOTAL];
        bit       starts[TOTAL];
        int       ord[TOTAL];
        int       opened;
        grant_t   pending[$];
        int       granted, refused, exhausted, checked;

        function void note_request(input logic [15:0] bytes);
            grant_t g;
            int req, total, rounded, need, page, slot, idx, buddy, o;
            bit hit;
            g.kind = ST_ZERO;
            g.offset = '0;
            g.order = '0;
            hit = 0;
            req = bytes;
            if (req != 0) begin
                if (req < SMALLEST_REQ) req = SMALLEST_REQ;
                total = req + HEADER_BYTES;
                rounded = 1;
                while (rounded < total) rounded <<= 1;
                if (rounded > PAGE_BYTES) g.kind = ST_LARGE;
                else begin
                    need = 0;
                    while (need < TOP_ORDER && (MIN_BLOCK_BYTES << need) < rounded) need++;
                    for (int p = 0; p < opened && !hit; p++)
                        for (int s = 0; s < SLOTS_PER_PAGE && !hit; s++) begin
                            idx = p * SLOTS_PER_PAGE + s;
                            if (starts[idx] && !used[idx] && ord[idx] >= need) begin
                                page = p;
                                slot = s;
                                hit = 1;
                            end
                        end
                    if (!hit && opened >= NUM_PAGES) g.kind = ST_EXHAUST;
                    else begin
                        if (!hit) begin
                            page = opened++;
                            slot = 0;
                            idx = page * SLOTS_PER_PAGE;
                            starts[idx] = 1;
                            ord[idx] = TOP_ORDER;
                            used[idx] = 0;
                        end
                        idx = page * SLOTS_PER_PAGE + slot;
                        while (ord[idx] > need) begin
                            o = ord[idx] - 1;
                            buddy = idx + (1 << o);
                            ord[idx] = o;
                            if (buddy < TOTAL) begin
                                starts[buddy] = 1;
                                ord[buddy] = o;
                                used[buddy] = 0;
                            end
                        end
                        used[idx] = 1;
                        g.kind = ST_GRANT;
                        g.offset = 16'(page * PAGE_BYTES + slot * MIN_BLOCK_BYTES
                                       + HEADER_BYTES);
                        g.order = 3'(ord[idx]);
                    end
                end
            end
            if (g.kind == ST_GRANT) granted++;
            else if (g.kind == ST_EXHAUST) exhausted++;
            else refused++;
            pending.push_back(g);
        endfunction

        task check_result(input logic [23:0] word);
            grant_t g;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", word));
                return;
            end
            g = pending.pop_front();
            if (word[1:0] !== g.kind)
                report_mismatch($sformatf("status %0d, predicted %0d", word[1:0], g.kind));
            if (word[17:2] !== g.offset)
                report_mismatch($sformatf("offset %h, predicted %h", word[17:2], g.offset));
            if (word[20:18] !== g.order)
                report_mismatch($sformatf("order %0d, predicted %0d", word[20:18], g.order));
            if (word[23:21] !== 3'b0)
                report_mismatch($sformatf("padding bits set in %h", word));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;

    pool_scoreboard pool = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    buddy_block_allocator DUT (.*);

    initial forever #1 clk = ~clk;

    initial
    begin
        #20000000;
        $display("buddy_block_allocator: mismatch");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) pool.check_result(m_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high between back-to-back transfers; it drops only for idle cycles.
    task automatic send_request(input logic [15:0] bytes);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= bytes;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pool.note_request(bytes);
    endtask

    // Mostly small sizes so pages fill with many blocks; a share of large and refused ones.
    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 16'd0;
        if (r < 8) return 16'($urandom_range(65535));
        if (r < 60) return 16'($urandom_range(1, 100));
        if (r < 90) return 16'($urandom_range(1, 1000));
        return 16'($urandom_range(1, PAGE_BYTES));
    endfunction

    task automatic drain_results();
        s_tvalid <= 0;
        while (pool.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] directed[$];
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        directed = '{16'd0, 16'd1, 16'd7, 16'd8, 16'd32, 16'd33, 16'd96, 16'd97,
                     16'd4064, 16'd4065, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA,
                     16'd2000, 16'd1000, 16'd480, 16'd224, 16'd100, 16'd1};
        foreach (directed[i]) send_request(directed[i]);
        // Long receiver hold-off while requests keep coming fills the input queue.
        hold_off = 300;
        for (int i = 0; i < 8; i++) send_request(16'($urandom_range(1, 200)));
        drain_results();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 34) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 68 : 34) : 0;
            for (int i = 0; i < 340; i++) send_request(pick_size());
        end
        drain_results();
        $display("Covered %0d requests: %0d grants, %0d refusals, %0d exhausted.",
                 pool.checked, pool.granted, pool.refused, pool.exhausted);
        $display("Pages opened at the end: %0d of %0d.", pool.opened, NUM_PAGES);
        if (fail_count == 0)
            $display("buddy_block_allocator: match");
        else
            $display("buddy_block_allocator: mismatch");
        $finish;
    end
endmodule

[filelist.f]
src/bba_pkg.sv
src/bba_front.sv
src/bba_engine.sv
src/buddy_block_allocator.sv
tb/buddy_block_allocator_tb.sv
